// File: rtl/core/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

    localparam logic [8:0] HUE_MAX = 9'd359;
    localparam logic [6:0] PCT_MAX = 7'd100;
    localparam logic [7:0] FULL    = 8'd255;

    // Sector upper bounds; each bound belongs to the sector below it.
    localparam logic [8:0] HUE_B1 = 9'd60;
    localparam logic [8:0] HUE_B2 = 9'd120;
    localparam logic [8:0] HUE_B3 = 9'd180;
    localparam logic [8:0] HUE_B4 = 9'd240;
    localparam logic [8:0] HUE_B5 = 9'd300;

    // x / 100 == (x * 5243) >> 19 for every x below 43699.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [7:0]      t_level;
    typedef logic [2:0][7:0] t_rgb;

    typedef struct packed {
        logic prod_en;
        logic quot_en;
    } t_stage_en;

    // 425 * deg / 100 reduces to 17 * deg / 4; deg stays within 0..60.
    function automatic t_level ramp(input logic [5:0] deg);
        logic [9:0] x17;
        x17  = {deg, 4'b0000} + {4'b0000, deg};
        ramp = x17[9:2];
    endfunction

endpackage

// File: rtl/core/hsv2rgb_sector.sv
module hsv2rgb_sector (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [8:0]          i_hue,
    input  logic [6:0]          i_saturation,
    input  logic [6:0]          i_brightness,
    output hsv2rgb_pkg::t_rgb   o_rgb,
    output logic [6:0]          o_inv_sat,
    output logic [6:0]          o_bright
);

    logic [8:0]         hue_c;
    logic [6:0]         sat_c;
    logic [6:0]         bri_c;
    hsv2rgb_pkg::t_rgb  n_rgb;
    hsv2rgb_pkg::t_rgb  r_rgb;
    logic [6:0]         r_inv_sat;
    logic [6:0]         r_bright;

    always_comb begin
        hue_c = (i_hue > hsv2rgb_pkg::HUE_MAX) ? hsv2rgb_pkg::HUE_MAX : i_hue;
        sat_c = (i_saturation > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : i_saturation;
        bri_c = (i_brightness > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : i_brightness;

        n_rgb = '0;
        if (hue_c <= hsv2rgb_pkg::HUE_B1) begin
            n_rgb[hsv2rgb_pkg::CH_RED]   = hsv2rgb_pkg::FULL;
            n_rgb[hsv2rgb_pkg::CH_GREEN] = hsv2rgb_pkg::ramp(hue_c[5:0]);
        end else if (hue_c <= hsv2rgb_pkg::HUE_B2) begin
            n_rgb[hsv2rgb_pkg::CH_RED]   = hsv2rgb_pkg::FULL
                - hsv2rgb_pkg::ramp(6'(hue_c - hsv2rgb_pkg::HUE_B1));
            n_rgb[hsv2rgb_pkg::CH_GREEN] = hsv2rgb_pkg::FULL;
        end else if (hue_c <= hsv2rgb_pkg::HUE_B3) begin
            n_rgb[hsv2rgb_pkg::CH_GREEN] = hsv2rgb_pkg::FULL;
            n_rgb[hsv2rgb_pkg::CH_BLUE]  =
                hsv2rgb_pkg::ramp(6'(hue_c - hsv2rgb_pkg::HUE_B2));
        end else if (hue_c <= hsv2rgb_pkg::HUE_B4) begin
            n_rgb[hsv2rgb_pkg::CH_GREEN] = hsv2rgb_pkg::FULL
                - hsv2rgb_pkg::ramp(6'(hue_c - hsv2rgb_pkg::HUE_B3));
            n_rgb[hsv2rgb_pkg::CH_BLUE]  = hsv2rgb_pkg::FULL;
        end else if (hue_c <= hsv2rgb_pkg::HUE_B5) begin
            n_rgb[hsv2rgb_pkg::CH_RED]   =
                hsv2rgb_pkg::ramp(6'(hue_c - hsv2rgb_pkg::HUE_B4));
            n_rgb[hsv2rgb_pkg::CH_BLUE]  = hsv2rgb_pkg::FULL;
        end else begin
            n_rgb[hsv2rgb_pkg::CH_RED]   = hsv2rgb_pkg::FULL;
            n_rgb[hsv2rgb_pkg::CH_BLUE]  = hsv2rgb_pkg::FULL
                - hsv2rgb_pkg::ramp(6'(hue_c - hsv2rgb_pkg::HUE_B5));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb     <= n_rgb;
            r_inv_sat <= hsv2rgb_pkg::PCT_MAX - sat_c;
            r_bright  <= bri_c;
        end
    end

    assign o_rgb     = r_rgb;
    assign o_inv_sat = r_inv_sat;
    assign o_bright  = r_bright;

endmodule

// File: rtl/core/hsv2rgb_mulscale.sv
// Two stages: base + a * b / 100, product registered, then reciprocal divide.
module hsv2rgb_mulscale (
    input  logic                   i_clk,
    input  hsv2rgb_pkg::t_stage_en i_en,
    input  logic [7:0]             i_a,
    input  logic [6:0]             i_b,
    input  logic [7:0]             i_base,
    output logic [7:0]             o_res
);

    logic [14:0] r_prod;
    logic [7:0]  r_base;
    logic [27:0] recip_prod;
    logic [7:0]  quot;
    logic [7:0]  r_res;

    always_ff @(posedge i_clk) begin
        if (i_en.prod_en) begin
            r_prod <= 15'(i_a * i_b);
            r_base <= i_base;
        end
    end

    assign recip_prod = 28'(r_prod * hsv2rgb_pkg::RECIP_100);
    assign quot       = recip_prod[hsv2rgb_pkg::RECIP_SHIFT +: 8];

    always_ff @(posedge i_clk) begin
        if (i_en.quot_en) begin
            r_res <= 8'(r_base + quot);
        end
    end

    assign o_res = r_res;

endmodule

// File: rtl/core/hsv_to_rgb_converter_unit.sv
// HSV to RGB converter.
//
// Input channel: i_valid / o_stall carry one word of hue (degrees),
// saturation and brightness (percent). Out-of-range values clamp to 359
// and 100. Output channel: o_valid / i_stall carry one word of 8-bit red,
// green and blue levels, one output word per input word, in order.
//
// Throughput is one word per cycle when nothing stalls. Stages, in order:
// sector select and hue ramp, desaturation product, desaturation divide,
// brightness product, brightness divide. A divide by 100 is a multiply by a
// 13-bit reciprocal and a shift.
//
// Each stage holds its word while the next stage is full and blocked, and
// advances into empty slots otherwise, so bubbles are squeezed out. When
// the receiver stalls, the output word holds steady and the pipe keeps
// filling; o_stall rises only once all five stages hold words.
//
// Reset clears all stage valid bits; data registers are not reset.
module hsv_to_rgb_converter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [8:0] i_hue,
    input  logic [6:0] i_saturation,
    input  logic [6:0] i_brightness,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    localparam int NSTG = 5;

    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  n_vld;
    logic [NSTG:0]    adv;     // adv[k]: stage k may load this cycle
    logic [NSTG-1:0]  vld_in;

    hsv2rgb_pkg::t_rgb sect_rgb;
    hsv2rgb_pkg::t_rgb desat_rgb;
    hsv2rgb_pkg::t_rgb out_rgb;
    logic [6:0]        sect_inv_sat;
    logic [6:0]        sect_bright;
    logic [6:0]        r_bright1;
    logic [6:0]        r_bright2;

    hsv2rgb_pkg::t_stage_en desat_en;
    hsv2rgb_pkg::t_stage_en bright_en;

    // Ready chain: a stage loads when empty or when its word moves on.
    always_comb begin
        adv[NSTG] = !i_stall;
        for (int k = NSTG - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
        vld_in = {r_vld[NSTG-2:0], i_valid};
        for (int k = 0; k < NSTG; k++) begin
            n_vld[k] = adv[k] ? vld_in[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_vld[NSTG-1];

    // Stage 0: clamp, pick sector, ramp the moving channel.
    hsv2rgb_sector u_sector (
        .i_clk        (i_clk),
        .i_en         (adv[0]),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_rgb        (sect_rgb),
        .o_inv_sat    (sect_inv_sat),
        .o_bright     (sect_bright)
    );

    // Carry brightness alongside the desaturation stages.
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_bright1 <= sect_bright;
        end
        if (adv[2]) begin
            r_bright2 <= r_bright1;
        end
    end

    assign desat_en  = '{prod_en: adv[1], quot_en: adv[2]};
    assign bright_en = '{prod_en: adv[3], quot_en: adv[4]};

    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        // Stages 1-2: raise toward full by (255 - c) * (100 - s) / 100.
        hsv2rgb_mulscale u_desat (
            .i_clk  (i_clk),
            .i_en   (desat_en),
            .i_a    (hsv2rgb_pkg::FULL - sect_rgb[ch]),
            .i_b    (sect_inv_sat),
            .i_base (sect_rgb[ch]),
            .o_res  (desat_rgb[ch])
        );

        // Stages 3-4: scale by brightness, c * v / 100.
        hsv2rgb_mulscale u_bright (
            .i_clk  (i_clk),
            .i_en   (bright_en),
            .i_a    (desat_rgb[ch]),
            .i_b    (r_bright2),
            .i_base (8'd0),
            .o_res  (out_rgb[ch])
        );
    end

    assign o_red   = out_rgb[hsv2rgb_pkg::CH_RED];
    assign o_green = out_rgb[hsv2rgb_pkg::CH_GREEN];
    assign o_blue  = out_rgb[hsv2rgb_pkg::CH_BLUE];

endmodule

// File: rtl/core/hsv2rgb_checker.sv
module hsv2rgb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    // Output word waits while stalled.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable({o_red, o_green, o_blue}))
        else $error("output word changed under stall");

    // Reset empties the pipe.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Input backs up only when the output is full and blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output can drain");

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_checker u_hsv2rgb_checker (.*);

// File: verif/testbench.sv
module testbench;
    import hsv2rgb_pkg::*;

    // Hue ramp slope in hundredths of a level per degree.
    localparam int unsigned RAMP_PER_DEG   = 425;
    localparam int unsigned RANDOM_WORDS   = 2000;
    // Cycles to linger after the last result; the pipe is five stages deep.
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned REPORT_LIMIT   = 10;

    typedef struct {
        logic [8:0] hue;
        logic [6:0] saturation;
        logic [6:0] brightness;
        logic       drain_first;  // hold this word back until the pipe is empty
    } color_request_t;

    typedef struct {
        t_level red;
        t_level green;
        t_level blue;
    } color_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [8:0] i_hue = '0;
    logic [6:0] i_saturation = '0;
    logic [6:0] i_brightness = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;

    color_request_t pending_requests[$];
    color_t         expected_colors[$];
    color_t         want;
    int unsigned    total_requests = 0;
    int unsigned    requests_taken = 0;
    int unsigned    colors_seen = 0;
    int unsigned    mismatches = 0;
    int unsigned    quiet_cycles = 0;

    hsv_to_rgb_converter_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Color prediction
    // ------------------------------------------------------------------

    function automatic int unsigned hue_ramp(input int unsigned deg);
        return (RAMP_PER_DEG * deg) / PCT_MAX;
    endfunction

    // Clamp the inputs, pick the hue sector, wash toward white by the
    // missing saturation, then scale by brightness. Every divide truncates.
    function automatic color_t hsv_color(input logic [8:0] hue,
                                         input logic [6:0] sat,
                                         input logic [6:0] bri);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned lvl[3];
        int          ch;
        color_t      c;
        h = (hue > HUE_MAX) ? HUE_MAX : hue;
        s = (sat > PCT_MAX) ? PCT_MAX : sat;
        v = (bri > PCT_MAX) ? PCT_MAX : bri;
        // Each sector bound belongs to the sector below it.
        if (h <= HUE_B1) begin
            lvl[0] = FULL; lvl[1] = hue_ramp(h);              lvl[2] = 0;
        end else if (h <= HUE_B2) begin
            lvl[0] = FULL - hue_ramp(h - HUE_B1); lvl[1] = FULL; lvl[2] = 0;
        end else if (h <= HUE_B3) begin
            lvl[0] = 0;    lvl[1] = FULL; lvl[2] = hue_ramp(h - HUE_B2);
        end else if (h <= HUE_B4) begin
            lvl[0] = 0;    lvl[1] = FULL - hue_ramp(h - HUE_B3); lvl[2] = FULL;
        end else if (h <= HUE_B5) begin
            lvl[0] = hue_ramp(h - HUE_B4); lvl[1] = 0; lvl[2] = FULL;
        end else begin
            lvl[0] = FULL; lvl[1] = 0; lvl[2] = FULL - hue_ramp(h - HUE_B5);
        end
        for (ch = 0; ch < 3; ch++) begin
            lvl[ch] = lvl[ch] + ((FULL - lvl[ch]) * (PCT_MAX - s)) / PCT_MAX;
            lvl[ch] = (lvl[ch] * v) / PCT_MAX;
        end
        c.red   = t_level'(lvl[0]);
        c.green = t_level'(lvl[1]);
        c.blue  = t_level'(lvl[2]);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Idle schedule: the run is split in thirds by words taken. First the
    // sender idles lightly and the receiver heavily, then the reverse, then
    // neither side idles at all.
    // ------------------------------------------------------------------

    function automatic int unsigned sender_idle_pct(input int unsigned taken);
        case ((taken * 3) / total_requests)
            0:       return 20;
            1:       return 70;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct(input int unsigned taken);
        case ((taken * 3) / total_requests)
            0:       return 70;
            1:       return 20;
            default: return 0;
        endcase
    endfunction

    task automatic queue_request(input logic [8:0] hue, input logic [6:0] sat,
                                 input logic [6:0] bri, input logic drain);
        color_request_t req;
        req.hue         = hue;
        req.saturation  = sat;
        req.brightness  = bri;
        req.drain_first = drain;
        pending_requests.push_back(req);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next pending word whenever the current one has
    // been taken (or none is up). Never drop valid because of a stall.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            // A word marked drain_first waits until every word taken so far,
            // counting the one taken at this edge, has come back out.
            if (pending_requests.size() > 0
                && $urandom_range(0, 99) >= sender_idle_pct(requests_taken)
                && !(pending_requests[0].drain_first
                     && (requests_taken + (i_valid ? 1 : 0))
                        != (colors_seen + ((o_valid && !i_stall) ? 1 : 0)))) begin
                i_valid      <= 1'b1;
                i_hue        <= pending_requests[0].hue;
                i_saturation <= pending_requests[0].saturation;
                i_brightness <= pending_requests[0].brightness;
                void'(pending_requests.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: drive the receiver stall, check each delivered word against
    // the oldest prediction, and record a prediction for each word taken.
    // Check before recording so a word can never match its own input edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < receiver_stall_pct(requests_taken));
            if (o_valid && !i_stall) begin
                colors_seen <= colors_seen + 1;
                if (expected_colors.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected word: r=%0d g=%0d b=%0d",
                                 o_red, o_green, o_blue);
                    mismatches++;
                end else begin
                    want = expected_colors.pop_front();
                    if (o_red !== want.red || o_green !== want.green
                        || o_blue !== want.blue) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("word %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     colors_seen, want.red, want.green, want.blue,
                                     o_red, o_green, o_blue);
                        mismatches++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                requests_taken <= requests_taken + 1;
                expected_colors.push_back(hsv_color(i_hue, i_saturation, i_brightness));
            end
        end
    end

    // Watchdog: bail out when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned n_directed;
        int unsigned k;
        logic [8:0]  hue;
        logic [6:0]  sat;
        logic [6:0]  bri;

        // Sector bounds and their neighbors at full saturation and value,
        // plus hue above range.
        queue_request(9'd0,   7'd100, 7'd100, 1'b0);
        queue_request(9'd60,  7'd100, 7'd100, 1'b0);
        queue_request(9'd61,  7'd100, 7'd100, 1'b0);
        queue_request(9'd120, 7'd100, 7'd100, 1'b0);
        queue_request(9'd121, 7'd100, 7'd100, 1'b0);
        queue_request(9'd180, 7'd100, 7'd100, 1'b0);
        queue_request(9'd181, 7'd100, 7'd100, 1'b0);
        queue_request(9'd240, 7'd100, 7'd100, 1'b0);
        queue_request(9'd241, 7'd100, 7'd100, 1'b0);
        queue_request(9'd300, 7'd100, 7'd100, 1'b0);
        queue_request(9'd301, 7'd100, 7'd100, 1'b0);
        queue_request(9'd359, 7'd100, 7'd100, 1'b0);
        queue_request(9'd360, 7'd100, 7'd100, 1'b0);
        queue_request(9'd511, 7'd100, 7'd100, 1'b0);
        // Saturation and brightness at zero, at the limit and above range.
        queue_request(9'd200, 7'd0,   7'd100, 1'b0);
        queue_request(9'd30,  7'd127, 7'd127, 1'b0);
        queue_request(9'd330, 7'd101, 7'd50,  1'b0);
        queue_request(9'd90,  7'd50,  7'd101, 1'b0);
        queue_request(9'd0,   7'd0,   7'd0,   1'b0);
        queue_request(9'd511, 7'd127, 7'd127, 1'b0);
        queue_request(9'd150, 7'd37,  7'd0,   1'b0);
        n_directed = pending_requests.size();

        for (k = 0; k < RANDOM_WORDS; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: hue = 9'($urandom_range(0, 359));
                6, 7:             hue = 9'($urandom_range(0, 511));
                // Hover around an interior sector bound.
                default:          hue = 9'(HUE_B1 * $urandom_range(1, 5) - 1
                                           + $urandom_range(0, 2));
            endcase
            sat = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 100));
            bri = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 100));
            // Drain the pipe completely a few times along the way.
            queue_request(hue, sat, bri,
                          k == 0 || k == RANDOM_WORDS / 2 || k == (RANDOM_WORDS * 5) / 6);
        end
        total_requests = n_directed + RANDOM_WORDS;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (requests_taken == total_requests && colors_seen >= total_requests);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_colors.size() != 0) begin
            $display("%0d predicted words never arrived", expected_colors.size());
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
